// File: src/tbg_pkg.sv
// Shared types and codes of the two-body gravity step block.
package tbg_pkg;

	localparam int MU_BITS = 48;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_LOAD_P = 2'd1;
	localparam logic [1:0] FUNC_LOAD_S = 2'd2;

	localparam logic CFG_MU_STAR   = 1'b0;
	localparam logic CFG_MU_PLANET = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_LOAD_P,
		OP_LOAD_S,
		OP_DIFF,
		OP_START,
		OP_STEP,
		OP_STORE,
		OP_POS,
		OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		PH_SQX,
		PH_SQY,
		PH_SQRT,
		PH_DFP,
		PH_DFS,
		PH_DDX,
		PH_DDY,
		PH_AXP,
		PH_AYP,
		PH_AXS,
		PH_AYS
	} phase_t;

	typedef struct packed {
		op_t    op;
		phase_t phase;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       zero;
	} stat_t;

endpackage

// File: src/tbg_if.sv
// Valid/ready channel interfaces for input items and result words.
interface tbg_in_if #(parameter int W = 48);
	logic         valid;
	logic         ready;
	logic [1:0]   func;
	logic [W-1:0] load_pos_x;
	logic [W-1:0] load_pos_y;
	logic [W-1:0] load_vel_x;
	logic [W-1:0] load_vel_y;

	modport source(output valid, func, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
		input ready);
	modport sink(input valid, func, load_pos_x, load_pos_y, load_vel_x, load_vel_y,
		output ready);
endinterface

interface tbg_out_if #(parameter int W = 48);
	logic         valid;
	logic         ready;
	logic [W-1:0] planet_x;
	logic [W-1:0] planet_y;
	logic [W-1:0] planet_vx;
	logic [W-1:0] planet_vy;
	logic [W-1:0] star_x;
	logic [W-1:0] star_y;
	logic [W-1:0] star_vx;
	logic [W-1:0] star_vy;
	logic         coincident;

	modport source(output valid, planet_x, planet_y, planet_vx, planet_vy,
		star_x, star_y, star_vx, star_vy, coincident, input ready);
	modport sink(input valid, planet_x, planet_y, planet_vx, planet_vy,
		star_x, star_y, star_vx, star_vy, coincident, output ready);
endinterface

// File: src/tbg_ctrl.sv
// Sequencer of the gravity step: walks the datapath through its phases.
module tbg_ctrl #(
	parameter int W     = 48,
	parameter int NUM_W = 96
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  tbg_pkg::stat_t  stat,
	output tbg_pkg::cmd_t   cmd
);
	import tbg_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DIFF,
		ST_START,
		ST_RUN,
		ST_STORE,
		ST_POS,
		ST_FINISH
	} state_t;

	state_t             state_q;
	phase_t             phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               in_ready_q;
	logic               out_valid_q;
	logic               out_free;

	function automatic logic [CNT_W-1:0] last_step(input phase_t ph);
		logic [CNT_W-1:0] n;
		unique case (ph)
			PH_DFP, PH_DFS, PH_DDX, PH_DDY: n = CNT_W'(NUM_W - 1);
			default:                        n = CNT_W'(W - 1);
		endcase
		return n;
	endfunction

	function automatic phase_t next_phase(input phase_t ph);
		phase_t n;
		unique case (ph)
			PH_SQX:  n = PH_SQY;
			PH_SQY:  n = PH_SQRT;
			PH_SQRT: n = PH_DFP;
			PH_DFP:  n = PH_DFS;
			PH_DFS:  n = PH_DDX;
			PH_DDX:  n = PH_DDY;
			PH_DDY:  n = PH_AXP;
			PH_AXP:  n = PH_AYP;
			PH_AYP:  n = PH_AXS;
			PH_AXS:  n = PH_AYS;
			default: n = PH_AYS;
		endcase
		return n;
	endfunction

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.phase = phase_q;
		cmd.op    = OP_NONE;
		unique case (state_q)
			ST_IDLE:     cmd.op = (in_valid && in_ready_q) ? OP_ACCEPT : OP_NONE;
			ST_DISPATCH: begin
				priority case (stat.func)
					FUNC_LOAD_P: cmd.op = OP_LOAD_P;
					FUNC_LOAD_S: cmd.op = OP_LOAD_S;
					default:     cmd.op = OP_NONE;
				endcase
			end
			ST_DIFF:     cmd.op = OP_DIFF;
			ST_START:    cmd.op = OP_START;
			ST_RUN:      cmd.op = OP_STEP;
			ST_STORE:    cmd.op = OP_STORE;
			ST_POS:      cmd.op = OP_POS;
			ST_FINISH:   cmd.op = out_free ? OP_OUT : OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SQX;
			cnt_q       <= '0;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// refill the output register as the old word leaves
			if (state_q == ST_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: state_q <= (stat.func == FUNC_TICK) ? ST_DIFF : ST_FINISH;
				ST_DIFF: begin
					phase_q <= PH_SQX;
					state_q <= ST_START;
				end
				ST_START: begin
					cnt_q   <= last_step(phase_q);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q == '0)
						state_q <= ST_STORE;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_STORE: begin
					// skip the force terms when the bodies coincide
					if ((phase_q == PH_SQY && stat.zero) || phase_q == PH_AYS) begin
						state_q <= ST_POS;
					end else begin
						phase_q <= next_phase(phase_q);
						state_q <= ST_START;
					end
				end
				ST_POS: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/tbg_datapath.sv
// Datapath: body state, shared shift-add multiplier, square root and divider.
module tbg_datapath #(
	parameter int W     = 48,
	parameter int F     = 24,
	parameter int NUM_W = 96
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tbg_pkg::cmd_t               cmd,
	output tbg_pkg::stat_t              stat,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tbg_pkg::MU_BITS-1:0] cfg_data,
	input  logic [1:0]                  in_func,
	input  logic [W-1:0]                in_pos_x,
	input  logic [W-1:0]                in_pos_y,
	input  logic [W-1:0]                in_vel_x,
	input  logic [W-1:0]                in_vel_y,
	output logic [W-1:0]                o_planet_x,
	output logic [W-1:0]                o_planet_y,
	output logic [W-1:0]                o_planet_vx,
	output logic [W-1:0]                o_planet_vy,
	output logic [W-1:0]                o_star_x,
	output logic [W-1:0]                o_star_y,
	output logic [W-1:0]                o_star_vx,
	output logic [W-1:0]                o_star_vy,
	output logic                        o_coincident
);
	import tbg_pkg::*;

	localparam int DW = 2 * W;

	function automatic logic [63:0] isqrt_c(input logic [127:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (n >= ({64'd0, t} * {64'd0, t}))
				r = t;
		end
		return r;
	endfunction

	localparam logic [63:0]  V0      = isqrt_c(128'd5 << (2 * F));
	localparam logic [63:0]  SV0     = (V0 + 64'd10) / 64'd20;
	localparam logic [W-1:0] RST_PPX = W'(64'd350 << F);
	localparam logic [W-1:0] RST_PPY = W'(64'd500 << F);
	localparam logic [W-1:0] RST_PVY = W'(V0);
	localparam logic [W-1:0] RST_SPX = W'(64'd750 << F);
	localparam logic [W-1:0] RST_SVY = W'(64'd0 - SV0);
	localparam logic [MU_BITS-1:0] RST_MU_S = MU_BITS'(64'd2000 << F);
	localparam logic [MU_BITS-1:0] RST_MU_P = MU_BITS'(64'd100 << F);
	localparam logic [W-1:0] MAXV    = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV    = {1'b1, {(W-1){1'b0}}};
	localparam logic [W:0]   SBIT_Q  = {2'b01, {(W-1){1'b0}}};

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? MINV : MAXV;
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1])
			return s[W] ? MINV : MAXV;
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] magn(input logic [W-1:0] a);
		return a[W-1] ? (~a + 1'b1) : a;
	endfunction

	// sign and magnitude to a saturated two's complement word
	function automatic logic [W-1:0] pack(input logic neg, input logic [DW-1:0] m);
		logic [DW-1:0] lim;
		logic [W-1:0]  x;
		lim = neg ? (DW'(1) << (W - 1)) : ((DW'(1) << (W - 1)) - 1'b1);
		x   = (m > lim) ? lim[W-1:0] : m[W-1:0];
		return neg ? (~x + 1'b1) : x;
	endfunction

	// architected state
	logic [W-1:0]       ppx_q, ppy_q, pvx_q, pvy_q;
	logic [W-1:0]       spx_q, spy_q, svx_q, svy_q;
	logic [MU_BITS-1:0] mu_star_q, mu_planet_q;
	logic               coinc_q;

	// working registers
	logic [1:0]         func_q;
	logic [W-1:0]       ld_px_q, ld_py_q, ld_vx_q, ld_vy_q;
	logic [W-1:0]       magx_q, magy_q;
	logic               negx_q, negy_q;
	logic [DW-1:0]      sq_q;
	logic [W-1:0]       dist_q, fp_q, fs_q, dirx_q, diry_q;
	logic [DW-1:0]      ma_q, acc_q;
	logic [W-1:0]       mb_q;
	logic [DW-1:0]      sqv_q;
	logic [W+1:0]       srem_q;
	logic [W-1:0]       root_q;
	logic [NUM_W-1:0]   num_q;
	logic [DW-1:0]      rem_q, den_q;
	logic [W:0]         quo_q;
	logic               ovf_q;

	// combinational helpers
	logic [W-1:0]       dx, dy;
	logic [W-1:0]       mul_a, mul_b;
	logic [W+1:0]       s_r2, s_trial;
	logic               s_ge;
	logic [DW:0]        d_r2;
	logic               d_ge;
	logic [W-1:0]       force_sat;
	logic [DW-1:0]      prod;
	logic               acc_neg;
	logic [W-1:0]       accel;

	assign dx = sat_sub(spx_q, ppx_q);
	assign dy = sat_sub(spy_q, ppy_q);

	always_comb begin
		unique case (cmd.phase)
			PH_SQX:  begin mul_a = magx_q; mul_b = magx_q; end
			PH_SQY:  begin mul_a = magy_q; mul_b = magy_q; end
			PH_AXP:  begin mul_a = dirx_q; mul_b = fp_q;   end
			PH_AYP:  begin mul_a = diry_q; mul_b = fp_q;   end
			PH_AXS:  begin mul_a = dirx_q; mul_b = fs_q;   end
			default: begin mul_a = diry_q; mul_b = fs_q;   end
		endcase
	end

	assign s_r2    = {srem_q[W-1:0], sqv_q[DW-1:DW-2]};
	assign s_trial = {root_q, 2'b01};
	assign s_ge    = s_r2 >= s_trial;

	assign d_r2 = {rem_q, num_q[NUM_W-1]};
	assign d_ge = d_r2 >= {1'b0, den_q};

	assign force_sat = (ovf_q || quo_q > SBIT_Q) ? MINV : quo_q[W-1:0];

	assign prod = acc_q >> F;
	always_comb begin
		unique case (cmd.phase)
			PH_AXP:  acc_neg = negx_q;
			PH_AYP:  acc_neg = negy_q;
			PH_AXS:  acc_neg = !negx_q;
			default: acc_neg = !negy_q;
		endcase
	end
	assign accel = pack(acc_neg, prod);

	assign stat.func = func_q;
	assign stat.zero = (acc_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppx_q       <= RST_PPX;
			ppy_q       <= RST_PPY;
			pvx_q       <= '0;
			pvy_q       <= RST_PVY;
			spx_q       <= RST_SPX;
			spy_q       <= RST_PPY;
			svx_q       <= '0;
			svy_q       <= RST_SVY;
			mu_star_q   <= RST_MU_S;
			mu_planet_q <= RST_MU_P;
			coinc_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MU_STAR:   mu_star_q   <= cfg_data;
					CFG_MU_PLANET: mu_planet_q <= cfg_data;
					default:       mu_star_q   <= mu_star_q;
				endcase
			end
			unique case (cmd.op)
				OP_ACCEPT: coinc_q <= 1'b0;
				OP_LOAD_P: begin
					ppx_q <= ld_px_q;
					ppy_q <= ld_py_q;
					pvx_q <= ld_vx_q;
					pvy_q <= ld_vy_q;
				end
				OP_LOAD_S: begin
					spx_q <= ld_px_q;
					spy_q <= ld_py_q;
					svx_q <= ld_vx_q;
					svy_q <= ld_vy_q;
				end
				OP_STORE: begin
					unique case (cmd.phase)
						PH_SQY:  coinc_q <= (acc_q == '0);
						PH_AXP:  pvx_q   <= sat_add(pvx_q, accel);
						PH_AYP:  pvy_q   <= sat_add(pvy_q, accel);
						PH_AXS:  svx_q   <= sat_add(svx_q, accel);
						PH_AYS:  svy_q   <= sat_add(svy_q, accel);
						default: coinc_q <= coinc_q;
					endcase
				end
				OP_POS: begin
					ppx_q <= sat_add(ppx_q, pvx_q);
					ppy_q <= sat_add(ppy_q, pvy_q);
					spx_q <= sat_add(spx_q, svx_q);
					spy_q <= sat_add(spy_q, svy_q);
				end
				default: coinc_q <= coinc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				func_q  <= in_func;
				ld_px_q <= in_pos_x;
				ld_py_q <= in_pos_y;
				ld_vx_q <= in_vel_x;
				ld_vy_q <= in_vel_y;
			end
			OP_DIFF: begin
				magx_q <= magn(dx);
				magy_q <= magn(dy);
				negx_q <= dx[W-1];
				negy_q <= dy[W-1];
			end
			OP_START: begin
				unique case (cmd.phase)
					PH_SQRT: begin
						sqv_q  <= sq_q;
						srem_q <= '0;
						root_q <= '0;
					end
					PH_DFP, PH_DFS, PH_DDX, PH_DDY: begin
						unique case (cmd.phase)
							PH_DFP:  num_q <= NUM_W'(mu_star_q) << (2 * F);
							PH_DFS:  num_q <= NUM_W'(mu_planet_q) << (2 * F);
							PH_DDX:  num_q <= NUM_W'(magx_q) << F;
							default: num_q <= NUM_W'(magy_q) << F;
						endcase
						den_q <= (cmd.phase == PH_DFP || cmd.phase == PH_DFS) ?
							sq_q : DW'(dist_q);
						rem_q <= '0;
						quo_q <= '0;
						ovf_q <= 1'b0;
					end
					default: begin
						// the y square accumulates onto the x square
						if (cmd.phase != PH_SQY)
							acc_q <= '0;
						ma_q <= DW'(mul_a);
						mb_q <= mul_b;
					end
				endcase
			end
			OP_STEP: begin
				unique case (cmd.phase)
					PH_SQRT: begin
						srem_q <= s_ge ? (s_r2 - s_trial) : s_r2;
						root_q <= {root_q[W-2:0], s_ge};
						sqv_q  <= sqv_q << 2;
					end
					PH_DFP, PH_DFS, PH_DDX, PH_DDY: begin
						rem_q <= d_ge ? DW'(d_r2 - {1'b0, den_q}) : d_r2[DW-1:0];
						num_q <= num_q << 1;
						quo_q <= {quo_q[W-1:0], d_ge};
						ovf_q <= ovf_q | quo_q[W];
					end
					default: begin
						if (mb_q[0])
							acc_q <= acc_q + ma_q;
						ma_q <= ma_q << 1;
						mb_q <= mb_q >> 1;
					end
				endcase
			end
			OP_STORE: begin
				unique case (cmd.phase)
					PH_SQY:  sq_q   <= acc_q;
					PH_SQRT: dist_q <= root_q;
					PH_DFP:  fp_q   <= force_sat;
					PH_DFS:  fs_q   <= force_sat;
					PH_DDX:  dirx_q <= quo_q[W-1:0];
					PH_DDY:  diry_q <= quo_q[W-1:0];
					default: sq_q   <= sq_q;
				endcase
			end
			OP_OUT: begin
				o_planet_x   <= ppx_q;
				o_planet_y   <= ppy_q;
				o_planet_vx  <= pvx_q;
				o_planet_vy  <= pvy_q;
				o_star_x     <= spx_q;
				o_star_y     <= spy_q;
				o_star_vx    <= svx_q;
				o_star_vy    <= svy_q;
				o_coincident <= coinc_q;
			end
			default: func_q <= func_q;
		endcase
	end

endmodule

// File: src/two_body_gravity_step_core.sv
// Two-body gravity step: planet and star state advanced by semi-implicit Euler.
//
// Channels: items (sink) carries func and four load values; results (source)
// carries the whole state after each item plus the coincident flag. Every
// accepted item yields exactly one result word.
// Configuration: cfg_we writes cfg_data to mu_star (index 0) or mu_planet
// (index 1) at the clock edge; write only while the block is idle.
// Sequence: a load or an unused code skips the arithmetic and goes to the
// result. A tick walks one shift-add multiplier, one digit-by-digit square
// root and one restoring divider in turn, the divider over NUM_W =
// max(48 + 2*FRAC_BITS, WORD_BITS + FRAC_BITS) numerator bits; with
// coincident bodies it ends after the squares.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register, which holds it while the receiver stalls. An item
// finishing with the output still full waits for it to drain.
// Reset: asynchronous; the state returns to the starting orbit and both
// gravity constants to their defaults.
module two_body_gravity_step_core #(
	parameter int WORD_BITS = 48,
	parameter int FRAC_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tbg_in_if.sink                      items,
	tbg_out_if.source                   results,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tbg_pkg::MU_BITS-1:0] cfg_data
);
	import tbg_pkg::*;

	localparam int NUM_A = 48 + 2 * FRAC_BITS;
	localparam int NUM_B = WORD_BITS + FRAC_BITS;
	localparam int NUM_W = (NUM_A > NUM_B) ? NUM_A : NUM_B;

	cmd_t  cmd;
	stat_t stat;

	tbg_ctrl #(.W(WORD_BITS), .NUM_W(NUM_W)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tbg_datapath #(.W(WORD_BITS), .F(FRAC_BITS), .NUM_W(NUM_W)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_func      (items.func),
		.in_pos_x     (items.load_pos_x),
		.in_pos_y     (items.load_pos_y),
		.in_vel_x     (items.load_vel_x),
		.in_vel_y     (items.load_vel_y),
		.o_planet_x   (results.planet_x),
		.o_planet_y   (results.planet_y),
		.o_planet_vx  (results.planet_vx),
		.o_planet_vy  (results.planet_vy),
		.o_star_x     (results.star_x),
		.o_star_y     (results.star_y),
		.o_star_vx    (results.star_vx),
		.o_star_vy    (results.star_vy),
		.o_coincident (results.coincident)
	);

endmodule

// File: src/tbg_checker.sv
// Port-level checks of the gravity step core and their binding.
module tbg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	// hold a result word until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// one item in flight: drop ready after an acceptance
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is at work");

	// a fresh result frees the input side at once
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("input not ready when a result appeared");

endmodule

bind two_body_gravity_step_core tbg_checker u_tbg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready)
);

// File: sim/tbg_state_checker.sv
// State checker: predicts every result word of the gravity step core and compares it.
module tbg_state_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	tbg_in_if                           items,
	tbg_out_if                          results,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tbg_pkg::MU_BITS-1:0] cfg_data,
	output int                          mismatches,
	output int                          outstanding,
	output int                          coincident_seen
);
	import tbg_pkg::*;

	localparam longint WMAX = 64'sd140737488355327;
	localparam longint WMIN = -64'sd140737488355328;
	localparam int PX = 0, PY = 1, PVX = 2, PVY = 3, SX = 4, SY = 5, SVX = 6, SVY = 7;

	typedef struct {
		longint v[8];
		bit     co;
	} orbit_word_t;

	longint      body[8];
	logic [47:0] mu_star, mu_planet;
	orbit_word_t orbit_q[$];

	function automatic longint clamp(longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	function automatic logic [63:0] root128(logic [127:0] n);
		logic [63:0]  r;
		logic [127:0] t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n) r = t[63:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] pull(logic [47:0] mu, logic [127:0] sq);
		logic [127:0] f;
		f = ({80'd0, mu} << 48) / sq;
		return (f > 128'd140737488355328) ? 64'd140737488355328 : f[63:0];
	endfunction

	// magnitude is truncated first, then signed
	function automatic longint accel(longint d, logic [63:0] dlen, logic [63:0] force_m,
			bit toward);
		logic [127:0] dir, prod;
		logic [63:0]  dmag;
		bit           neg;
		dmag = (d < 0) ? -d : d;
		dir  = ({64'd0, dmag} << 24) / {64'd0, dlen};
		prod = (dir * {64'd0, force_m}) >> 24;
		neg  = toward ? (d < 0) : !(d < 0);
		if (neg) return (prod > 128'd140737488355328) ? WMIN : -longint'(prod[63:0]);
		return (prod > 128'd140737488355327) ? WMAX : longint'(prod[63:0]);
	endfunction

	function automatic orbit_word_t advance(logic [1:0] f, logic [47:0] a, logic [47:0] b,
			logic [47:0] c, logic [47:0] d);
		orbit_word_t  w;
		longint       dx, dy;
		logic [63:0]  ax, ay, dlen, fp, fs;
		logic [127:0] sq;
		w.co = 0;
		case (f)
			FUNC_LOAD_P: begin
				body[PX] = $signed(a); body[PY] = $signed(b);
				body[PVX] = $signed(c); body[PVY] = $signed(d);
			end
			FUNC_LOAD_S: begin
				body[SX] = $signed(a); body[SY] = $signed(b);
				body[SVX] = $signed(c); body[SVY] = $signed(d);
			end
			FUNC_TICK: begin
				dx = clamp(body[SX] - body[PX]);
				dy = clamp(body[SY] - body[PY]);
				ax = (dx < 0) ? -dx : dx;
				ay = (dy < 0) ? -dy : dy;
				sq = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
				if (sq == 0) begin
					w.co = 1;
				end else begin
					dlen = root128(sq);
					fp = pull(mu_star, sq);
					fs = pull(mu_planet, sq);
					body[PVX] = clamp(body[PVX] + accel(dx, dlen, fp, 1));
					body[PVY] = clamp(body[PVY] + accel(dy, dlen, fp, 1));
					body[SVX] = clamp(body[SVX] + accel(dx, dlen, fs, 0));
					body[SVY] = clamp(body[SVY] + accel(dy, dlen, fs, 0));
				end
				// velocity first, then position
				body[PX] = clamp(body[PX] + body[PVX]);
				body[PY] = clamp(body[PY] + body[PVY]);
				body[SX] = clamp(body[SX] + body[SVX]);
				body[SY] = clamp(body[SY] + body[SVY]);
			end
			default: ;
		endcase
		w.v = body;
		return w;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	task automatic compare(orbit_word_t w);
		logic [47:0] seen[8];
		string       nm[8];
		seen = '{results.planet_x, results.planet_y, results.planet_vx, results.planet_vy,
			results.star_x, results.star_y, results.star_vx, results.star_vy};
		nm = '{"planet_x", "planet_y", "planet_vx", "planet_vy",
			"star_x", "star_y", "star_vx", "star_vy"};
		for (int i = 0; i < 8; i++)
			if (seen[i] !== w.v[i][47:0])
				report(nm[i], longint'($signed(seen[i])), w.v[i]);
		if (results.coincident !== w.co)
			report("coincident", longint'(results.coincident), longint'(w.co));
	endtask

	initial begin
		mismatches = 0;
		coincident_seen = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body = '{350 * 64'sd16777216, 500 * 64'sd16777216, 0, 64'sd37514995,
				750 * 64'sd16777216, 500 * 64'sd16777216, 0, -64'sd1875750};
			mu_star = 48'd33554432000;
			mu_planet = 48'd1677721600;
			orbit_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MU_STAR) mu_star = cfg_data;
				else mu_planet = cfg_data;
			end
			if (results.valid && results.ready) begin
				if (orbit_q.size() == 0) begin
					$display("mismatch: result word with nothing expected");
					mismatches++;
				end else begin
					compare(orbit_q.pop_front());
				end
			end
			if (items.valid && items.ready) begin
				orbit_q.insert(orbit_q.size(), advance(items.func, items.load_pos_x,
					items.load_pos_y, items.load_vel_x, items.load_vel_y));
				if (orbit_q[$].co) coincident_seen++;
			end
			outstanding <= orbit_q.size();
		end
	end
endmodule

// File: sim/tb_two_body_gravity_step_core.sv
// Testbench top: drives the gravity step core and gives the verdict.
module tb_two_body_gravity_step_core;
	import tbg_pkg::*;

	localparam longint CYCLE_LIMIT = 8_000_000;
	localparam logic [47:0] WORD_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] WORD_MIN = 48'h8000_0000_0000;
	localparam logic [47:0] ONE = 48'd16777216;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [MU_BITS-1:0] cfg_data = '0;
	int mismatches, outstanding, coincident_seen;
	int sent = 0, ticks = 0, loads = 0;
	bit calm = 0, stall_req = 0, stall_done = 0;
	longint cycles = 0;

	tbg_in_if #(48) item_ch ();
	tbg_out_if #(48) state_ch ();

	two_body_gravity_step_core dut (
		.clk(clk), .arst_n(arst_n), .items(item_ch), .results(state_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tbg_state_checker chk (
		.clk(clk), .arst_n(arst_n), .items(item_ch), .results(state_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding),
		.coincident_seen(coincident_seen)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_two_body_gravity_step_core failed");
			$finish;
		end
	end

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		int hold;
		hold = 0;
		state_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_req && !stall_done) begin
				stall_done = 1;
				hold = 3000;
			end
			if (hold > 0) begin
				hold--;
				state_ch.ready <= 0;
			end else begin
				state_ch.ready <= calm || ($urandom_range(99) >= 16);
			end
		end
	end

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	// whole units within +/- span, random fraction
	function automatic logic [47:0] rand_near(int span);
		longint v;
		v = (longint'($urandom_range(0, 2 * span)) - span) * 64'sd16777216
			+ $urandom_range(0, 24'hFFFFFF);
		return v[47:0];
	endfunction

	task automatic send(logic [1:0] f, logic [47:0] a, logic [47:0] b,
			logic [47:0] c, logic [47:0] d);
		if (!calm && $urandom_range(99) < 16) begin
			item_ch.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.func <= f;
		item_ch.load_pos_x <= a;
		item_ch.load_pos_y <= b;
		item_ch.load_vel_x <= c;
		item_ch.load_vel_y <= d;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		sent++;
		if (f == FUNC_TICK) ticks++;
		else loads++;
	endtask

	task automatic tick();
		send(FUNC_TICK, rand48(), rand48(), rand48(), rand48());
	endtask

	// drop valid and wait for every word to drain before touching the registers
	task automatic drain();
		item_ch.valid <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_mu(logic idx, logic [MU_BITS-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_phase(int n);
		int goal;
		goal = sent + n;
		while (sent < goal) begin
			if ($urandom_range(99) < 8) begin
				send(2'($urandom_range(0, 3)), rand48(), rand48(), rand48(), rand48());
			end else begin
				if ($urandom_range(3) == 0)
					send(FUNC_LOAD_P, rand48(), rand48(), rand_near(4), rand_near(4));
				else
					send(FUNC_LOAD_P, rand_near(1000), rand_near(1000),
						rand_near(3), rand_near(3));
				if ($urandom_range(9) == 0)
					send(FUNC_LOAD_S, rand48(), rand48(), rand48(), rand48());
				else
					send(FUNC_LOAD_S, rand_near(1000), rand_near(1000),
						rand_near(1), rand_near(1));
				repeat ($urandom_range(3, 12)) tick();
			end
		end
	endtask

	initial begin
		item_ch.valid = 0;
		item_ch.func = FUNC_TICK;
		item_ch.load_pos_x = '0;
		item_ch.load_pos_y = '0;
		item_ch.load_vel_x = '0;
		item_ch.load_vel_y = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// starting orbit, unused code, saturation, coincidence, tiny separation
		tick();
		tick();
		send(2'd3, rand48(), rand48(), rand48(), rand48());
		send(FUNC_LOAD_P, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
		send(FUNC_LOAD_S, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
		tick();
		tick();
		send(FUNC_LOAD_P, '0, '0, '0, '0);
		send(FUNC_LOAD_S, '0, '0, '0, '0);
		tick();
		send(FUNC_LOAD_S, '0, '0, ONE, WORD_MIN);
		tick();
		send(FUNC_LOAD_S, 48'd1, '0, '0, '0);
		send(FUNC_LOAD_P, '0, '0, '0, '0);
		tick();
		send(FUNC_LOAD_P, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
			48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
		send(FUNC_LOAD_S, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
			48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
		tick();
		send(FUNC_LOAD_P, WORD_MIN, '0, '0, '0);
		send(FUNC_LOAD_S, WORD_MAX, '0, '0, '0);
		tick();
		drain();

		// default constants, with the long hold-off in the middle
		random_phase(150);
		stall_req = 1;
		random_phase(220);
		drain();

		write_mu(CFG_MU_STAR, '1);
		write_mu(CFG_MU_PLANET, '0);
		send(FUNC_LOAD_S, 48'd1, 48'd1, '0, '0);
		send(FUNC_LOAD_P, '0, '0, '0, '0);
		tick();
		calm = 1;
		random_phase(150);
		calm = 0;
		random_phase(200);
		drain();

		write_mu(CFG_MU_STAR, '0);
		write_mu(CFG_MU_PLANET, '1);
		random_phase(350);
		drain();

		write_mu(CFG_MU_STAR, rand48());
		write_mu(CFG_MU_PLANET, 48'($urandom_range(0, 32'hFFFF_FFFF)) << 8);
		random_phase(400);
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d items: %0d ticks, %0d loads or unused codes", sent, ticks,
			loads);
		$display("four settings of the gravity constants, %0d coincident ticks",
			coincident_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_two_body_gravity_step_core passed");
		else
			$display("tb_two_body_gravity_step_core failed");
		$finish;
	end
endmodule
